### hdl/vrt_pkg.sv
// vrt_pkg: shared types, widths and codes for the voxel ray traversal block
// no dependencies; imported by vrt_div, vrt_sqrt and voxel_ray_traversal
`timescale 1ns / 1ps

package vrt_pkg;

  localparam int GRID_X_DEF      = 64;
  localparam int GRID_HEIGHT_DEF = 16;
  localparam int GRID_Z_DEF      = 64;
  localparam int TYPE_BITS_DEF   = 8;

  // voxel coordinate width during a walk, wide enough for the step cap
  localparam int CW = 14;
  // unsigned q.32 times, all ones stands for an axis that is never crossed
  localparam int TW = 58;
  localparam logic [TW-1:0] T_NEVER = '1;

  // shared divider: numerator and divisor widths
  localparam int DW  = 56;
  localparam int DDW = 20;

  // square root operand width
  localparam int SQW = 40;

  localparam int STEP_CAP = 4096;
  localparam int NW       = 13;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    FACE_LEFT   = 3'd0,
    FACE_RIGHT  = 3'd1,
    FACE_BACK   = 3'd2,
    FACE_FRONT  = 3'd3,
    FACE_BOTTOM = 3'd4,
    FACE_TOP    = 3'd5,
    FACE_NONE   = 3'd7
  } face_t;

  typedef enum logic [2:0] {
    JOB_BX  = 3'd0,
    JOB_BY  = 3'd1,
    JOB_BZ  = 3'd2,
    JOB_IX  = 3'd3,
    JOB_IY  = 3'd4,
    JOB_IZ  = 3'd5,
    JOB_LIM = 3'd6
  } job_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_ROOT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_LOOK,
    S_TEST,
    S_PICK,
    S_STEP,
    S_FIN
  } state_t;

endpackage

### hdl/vrt_ram.sv
// vrt_ram: generic single write port, single read port ram with registered read
// depends on nothing beyond its parameters
`timescale 1ns / 1ps

module vrt_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/vrt_div.sv
// vrt_div: shared restoring divider, one quotient bit per cycle
// depends on vrt_pkg for DW and DDW
`timescale 1ns / 1ps

module vrt_div
  import vrt_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  num,
  input  logic [DDW-1:0] den,
  output logic           busy,
  output logic           done,
  output logic [DW-1:0]  quo
);

  localparam int CNTW = $clog2(DW);

  logic [CNTW-1:0] cnt;
  logic [DDW-1:0]  rem;
  logic [DDW:0]    shifted;
  logic            fits;

  assign shifted = {rem, quo[DW-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? DDW'(shifted - {1'b0, den}) : DDW'(shifted);
    end
  end

endmodule

### hdl/vrt_sqrt.sv
// vrt_sqrt: bit pair integer square root, one result bit per cycle
// depends on vrt_pkg for SQW
`timescale 1ns / 1ps

module vrt_sqrt
  import vrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQW-1:0]     val,
  output logic               busy,
  output logic               done,
  output logic [SQW/2-1:0]   root
);

  localparam int ITER = SQW / 2;
  localparam int CNTW = $clog2(ITER);

  logic [CNTW-1:0] cnt;
  logic [SQW-1:0]  v;
  logic [SQW-1:0]  r;
  logic [SQW-1:0]  bitv;
  logic [SQW-1:0]  trial;

  assign trial = r + bitv;
  assign root  = r[ITER-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      r    <= '0;
      bitv <= SQW'(1) << (SQW - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### hdl/voxel_ray_traversal.sv
// voxel_ray_traversal: voxel store and grid walker with its setup sequencer
// depends on vrt_pkg, vrt_ram, vrt_div and vrt_sqrt
//
// Input channel (in_valid / in_stall): opcode 0 writes voxel_type at
// (voxel_x, voxel_y, voxel_z), if inside the grid, and gives no result.
// Opcode 1 casts a ray from origin_* along dir_* out to reach and gives one
// item on the output channel (out_valid / out_stall).
// A cast runs on one item at a time: squaring, the length root, seven
// divisions on the shared divider, then a look, pick and step per voxel
// visited, with a voxel store read and test only for voxels inside the grid,
// then a finish state. An all-zero direction skips the root and divisions.
// in_stall is high for the whole cast.
// Reset: a clearing pass writes air to every voxel, with in_stall high throughout.
// The result sits in an output register: while out_stall holds it, the
// block goes on taking writes and starts the next cast, which waits at
// its end until the register is free.
`timescale 1ns / 1ps

module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int GRID_X      = GRID_X_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int GRID_Z      = GRID_Z_DEF,
  parameter int TYPE_BITS   = TYPE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [5:0]         voxel_x,
  input  logic [3:0]         voxel_y,
  input  logic [5:0]         voxel_z,
  input  logic [7:0]         voxel_type,
  input  logic signed [23:0] origin_x,
  input  logic signed [23:0] origin_y,
  input  logic signed [23:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [15:0]        reach,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               aborted,
  output logic signed [11:0] hit_x,
  output logic signed [11:0] hit_y,
  output logic signed [11:0] hit_z,
  output logic [7:0]         hit_type,
  output logic [2:0]         entry_face,
  output logic               face_known
);

  localparam int XB = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YB = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int ZB = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int AW = XB + YB + ZB;

  localparam logic [11:0] GX_U = 12'(GRID_X);
  localparam logic [11:0] GY_U = 12'(GRID_HEIGHT);
  localparam logic [11:0] GZ_U = 12'(GRID_Z);
  localparam logic signed [CW-1:0] GX_S = CW'(GRID_X);
  localparam logic signed [CW-1:0] GY_S = CW'(GRID_HEIGHT);
  localparam logic signed [CW-1:0] GZ_S = CW'(GRID_Z);

  state_t state, state_next;

  logic [AW-1:0]        clr_addr;
  logic                 in_acc;
  logic                 fin_load;

  logic signed [23:0]   org_r [3];
  logic signed [15:0]   dir_r [3];
  logic [15:0]          reach_r;
  logic                 neg_r [3];
  logic signed [CW-1:0] cur [3];
  logic [TW-1:0]        bt [3];
  logic [TW-1:0]        ti [3];
  logic [TW-1:0]        limit;
  face_t                last_face;
  logic [NW-1:0]        n;
  axis_t                sel;
  logic [1:0]           k;
  logic [31:0]          prod;
  logic [31:0]          sq;
  logic [DDW-1:0]       lq;
  job_t                 job;
  logic                 hit_f;
  logic                 abort_f;
  logic [7:0]           type_r;

  // ram ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [TYPE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [TYPE_BITS-1:0] ram_rdata;

  // shared units
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic                 sqrt_start;
  logic                 sqrt_busy;
  logic                 sqrt_done;
  logic [DW-1:0]        div_num;
  logic [DDW-1:0]       div_den;
  logic [DW-1:0]        div_quo;
  logic [DDW-1:0]       root;

  logic [11:0]          wx, wy, wz;
  logic                 w_in_grid;
  logic [15:0]          wtype16;
  logic [15:0]          rtype16;

  logic signed [15:0]   dsq_sel;
  logic signed [31:0]   dsq;

  axis_t                ja;
  logic signed [15:0]   jdir;
  logic signed [23:0]   jorg;
  logic [15:0]          jmag;
  logic [23:0]          jorg_neg;
  logic [11:0]          jfrac;
  logic [12:0]          jrem;

  logic                 look_stop;
  logic                 look_nonneg;
  logic                 look_far;
  logic                 step_over;
  axis_t                pick;

  vrt_ram #(
    .WIDTH     (TYPE_BITS),
    .ADDR_BITS (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  vrt_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (SQW'({sq, 8'd0})),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (root)
  );

  // write item decode
  assign wx        = 12'(voxel_x);
  assign wy        = 12'(voxel_y);
  assign wz        = 12'(voxel_z);
  assign w_in_grid = (wx < GX_U) && (wy < GY_U) && (wz < GZ_U);
  assign wtype16   = 16'(voxel_type);
  assign rtype16   = 16'(ram_rdata);

  // squaring, one axis a cycle
  always_comb begin
    case (k)
      2'd0:    dsq_sel = dir_r[AX_X];
      2'd1:    dsq_sel = dir_r[AX_Y];
      2'd2:    dsq_sel = dir_r[AX_Z];
      default: dsq_sel = '0;
    endcase
  end
  assign dsq = dsq_sel * dsq_sel;

  // divider operand selection
  always_comb begin
    case (job)
      JOB_BX, JOB_IX: ja = AX_X;
      JOB_BY, JOB_IY: ja = AX_Y;
      default:        ja = AX_Z;
    endcase
  end
  assign jdir     = dir_r[ja];
  assign jorg     = org_r[ja];
  assign jmag     = jdir[15] ? 16'(16'sd0 - jdir) : 16'(jdir);
  assign jorg_neg = 24'd0 - 24'(jorg);
  assign jfrac    = jdir[15] ? jorg_neg[11:0] : jorg[11:0];
  assign jrem     = 13'd4096 - {1'b0, jfrac};

  always_comb begin
    case (job)
      JOB_BX, JOB_BY, JOB_BZ: begin
        div_num = DW'({jrem, 32'd0});
        div_den = DDW'(jmag);
      end
      JOB_IX, JOB_IY, JOB_IZ: begin
        div_num = DW'(1) << 44;
        div_den = DDW'(jmag);
      end
      default: begin
        div_num = DW'({reach_r, 40'd0});
        div_den = lq;
      end
    endcase
  end

  // walk decisions
  assign look_stop   = (n == NW'(STEP_CAP)) || (cur[AX_Y] >= GY_S);
  assign look_nonneg = !cur[AX_X][CW-1] && !cur[AX_Y][CW-1] && !cur[AX_Z][CW-1];
  assign look_far    = (cur[AX_X] >= GX_S) || (cur[AX_Z] >= GZ_S);
  assign step_over   = bt[sel] > limit;

  always_comb begin
    if (bt[AX_X] < bt[AX_Y]) begin
      pick = (bt[AX_X] < bt[AX_Z]) ? AX_X : AX_Z;
    end else begin
      pick = (bt[AX_Y] < bt[AX_Z]) ? AX_Y : AX_Z;
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign fin_load = (state == S_FIN) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && op_t'(opcode) == OP_CAST) state_next = S_SQ;
      end
      S_SQ: begin
        if (k == 2'd3) state_next = S_ROOT;
      end
      S_ROOT: begin
        state_next = (sq == '0) ? S_FIN : S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (sqrt_done) state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = (job == JOB_LIM) ? S_LOOK : S_DIV_GO;
      end
      S_LOOK: begin
        if (look_stop) state_next = S_FIN;
        else if (look_nonneg) state_next = look_far ? S_FIN : S_TEST;
        else state_next = S_PICK;
      end
      S_TEST: begin
        state_next = (ram_rdata != '0) ? S_FIN : S_PICK;
      end
      S_PICK: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        state_next = step_over ? S_FIN : S_LOOK;
      end
      S_FIN: begin
        if (fin_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = {cur[AX_X][XB-1:0], cur[AX_Y][YB-1:0], cur[AX_Z][ZB-1:0]};
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_stall  = 1'b0;
        ram_waddr = {wx[XB-1:0], wy[YB-1:0], wz[ZB-1:0]};
        ram_wdata = wtype16[TYPE_BITS-1:0];
        ram_we    = in_valid && op_t'(opcode) == OP_WRITE && w_in_grid;
      end
      S_ROOT: begin
        sqrt_start = (sq != '0);
      end
      S_DIV_GO: begin
        div_start = 1'b1;
      end
      S_LOOK: begin
        ram_re = !look_stop && look_nonneg && !look_far;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (fin_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && op_t'(opcode) == OP_CAST) begin
          org_r[AX_X] <= origin_x;
          org_r[AX_Y] <= origin_y;
          org_r[AX_Z] <= origin_z;
          dir_r[AX_X] <= dir_x;
          dir_r[AX_Y] <= dir_y;
          dir_r[AX_Z] <= dir_z;
          neg_r[AX_X] <= dir_x[15];
          neg_r[AX_Y] <= dir_y[15];
          neg_r[AX_Z] <= dir_z[15];
          reach_r     <= reach;
          cur[AX_X]   <= CW'(origin_x >>> 12);
          cur[AX_Y]   <= CW'(origin_y >>> 12);
          cur[AX_Z]   <= CW'(origin_z >>> 12);
          last_face   <= FACE_NONE;
          sq          <= '0;
          k           <= '0;
          n           <= '0;
          hit_f       <= 1'b0;
          abort_f     <= 1'b0;
        end
      end
      S_SQ: begin
        k <= k + 1'b1;
        if (k != 2'd3) prod <= unsigned'(dsq);
        if (k != 2'd0) sq <= sq + prod;
      end
      S_ROOT_WAIT: begin
        if (sqrt_done) begin
          lq  <= root;
          job <= JOB_BX;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (job)
            JOB_BX, JOB_BY, JOB_BZ: bt[ja] <= (jmag == '0) ? T_NEVER : TW'(div_quo);
            JOB_IX, JOB_IY, JOB_IZ: ti[ja] <= (jmag == '0) ? T_NEVER : TW'(div_quo);
            default:                limit  <= TW'(div_quo);
          endcase
          job <= job_t'(job + 1'b1);
        end
      end
      S_LOOK: begin
        if (!look_stop && look_nonneg && look_far) abort_f <= 1'b1;
      end
      S_TEST: begin
        type_r <= rtype16[7:0];
        if (ram_rdata != '0) hit_f <= 1'b1;
      end
      S_PICK: begin
        sel <= pick;
      end
      S_STEP: begin
        if (!step_over) begin
          cur[sel] <= neg_r[sel] ? cur[sel] - 1'b1 : cur[sel] + 1'b1;
          bt[sel]  <= bt[sel] + ti[sel];
          n        <= n + 1'b1;
          case (sel)
            AX_X:    last_face <= neg_r[sel] ? FACE_RIGHT : FACE_LEFT;
            AX_Y:    last_face <= neg_r[sel] ? FACE_TOP : FACE_BOTTOM;
            default: last_face <= neg_r[sel] ? FACE_FRONT : FACE_BACK;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      hit        <= hit_f;
      aborted    <= abort_f;
      hit_x      <= cur[AX_X][11:0];
      hit_y      <= cur[AX_Y][11:0];
      hit_z      <= cur[AX_Z][11:0];
      hit_type   <= hit_f ? type_r : 8'd0;
      entry_face <= (hit_f && last_face != FACE_NONE) ? last_face : FACE_LEFT;
      face_known <= hit_f && last_face != FACE_NONE;
    end
  end

  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR && state != S_IDLE |-> n <= NW'(STEP_CAP))
    else $error("walk ran past the step cap");

  a_hit_not_abort: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && aborted))
    else $error("item reports both hit and abort");

  a_face_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && face_known |-> hit && entry_face != FACE_NONE)
    else $error("entry face reported without a hit");

  a_pick_earliest: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> bt[sel] <= bt[AX_X] && bt[sel] <= bt[AX_Y] && bt[sel] <= bt[AX_Z])
    else $error("step axis is not the earliest boundary");

  a_pick_moving: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP && !step_over |-> dir_r[sel] != '0)
    else $error("step taken along an axis with no motion");

  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && sqrt_busy))
    else $error("divider and square root busy together");

endmodule

### test/voxel_ray_traversal_tb.sv
// voxel_ray_traversal_tb: self-checking bench for the voxel ray traversal block
// drives voxel writes and ray casts, predicts every cast result and checks it
// depends on vrt_pkg and the voxel_ray_traversal rtl
`timescale 1ns / 1ps

module voxel_ray_traversal_tb;
  import vrt_pkg::*;

  localparam int GX = 64;
  localparam int GY = 16;
  localparam int GZ = 64;
  localparam int WALK_CAP = 4096;
  localparam int IDLE_LIMIT = 300000;
  localparam longint unsigned NEVER = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    op_t                op;
    logic [5:0]         vx;
    logic [3:0]         vy;
    logic [5:0]         vz;
    logic [7:0]         vtype;
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic [15:0]        reach;
  } ray_item_t;

  typedef struct {
    logic               hit;
    logic               aborted;
    logic signed [11:0] x, y, z;
    logic [7:0]         htype;
    logic [2:0]         face;
    logic               face_known;
  } cast_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [5:0] voxel_x = '0;
  logic [3:0] voxel_y = '0;
  logic [5:0] voxel_z = '0;
  logic [7:0] voxel_type = '0;
  logic signed [23:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [15:0] reach = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit, aborted, face_known;
  logic signed [11:0] hit_x, hit_y, hit_z;
  logic [7:0] hit_type;
  logic [2:0] entry_face;

  ray_item_t pending_items[$];
  cast_result_t awaited_casts[$];
  ray_item_t cur_item;
  logic [7:0] grid[0:GX*GY*GZ-1];
  int errors = 0;
  int in_gap = 0;
  int out_hold = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  voxel_ray_traversal DUT (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cast_result_t trace_ray(ray_item_t it);
    longint unsigned bt[3], inc[3], lim, sq;
    int cur[3], stp[3], org[3], dir[3];
    int unsigned mag, f;
    int a, n;
    logic [7:0] v;
    face_t face;
    cast_result_t r;
    org[0] = int'(it.ox); org[1] = int'(it.oy); org[2] = int'(it.oz);
    dir[0] = int'(it.dx); dir[1] = int'(it.dy); dir[2] = int'(it.dz);
    sq = 0;
    face = FACE_NONE;
    r = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      cur[i] = org[i] >>> 12;
      sq += longint'(dir[i] * dir[i]);
      if (dir[i] == 0) begin
        stp[i] = 0;
        bt[i] = NEVER;
        inc[i] = NEVER;
      end else begin
        mag = (dir[i] > 0) ? dir[i] : -dir[i];
        f = (dir[i] > 0) ? (org[i] & 12'hFFF) : ((-org[i]) & 12'hFFF);
        stp[i] = (dir[i] > 0) ? 1 : -1;
        bt[i] = (64'(4096 - f) << 32) / mag;
        inc[i] = (64'd1 << 44) / mag;
      end
    end
    if (sq != 0) begin
      lim = (64'(it.reach) << 40) / root_floor(sq << 8);
      for (n = 0; n < WALK_CAP && cur[1] < GY; n++) begin
        if (cur[0] >= 0 && cur[1] >= 0 && cur[2] >= 0) begin
          if (cur[0] >= GX || cur[2] >= GZ) begin
            r.aborted = 1'b1;
            break;
          end
          v = grid[(cur[0] * GY + cur[1]) * GZ + cur[2]];
          if (v != 0) begin
            r.hit = 1'b1;
            r.htype = v;
            break;
          end
        end
        if (bt[0] < bt[1]) a = (bt[0] < bt[2]) ? 0 : 2;
        else a = (bt[1] < bt[2]) ? 1 : 2;
        if (bt[a] > lim) break;
        cur[a] += stp[a];
        bt[a] += inc[a];
        case (a)
          0: face = (stp[a] > 0) ? FACE_LEFT : FACE_RIGHT;
          1: face = (stp[a] > 0) ? FACE_BOTTOM : FACE_TOP;
          default: face = (stp[a] > 0) ? FACE_BACK : FACE_FRONT;
        endcase
      end
    end
    r.x = cur[0][11:0];
    r.y = cur[1][11:0];
    r.z = cur[2][11:0];
    if (r.hit && face != FACE_NONE) begin
      r.face = face;
      r.face_known = 1'b1;
    end
    return r;
  endfunction

  function automatic ray_item_t noise_item();
    ray_item_t it;
    it.op = op_t'($urandom_range(0, 1));
    it.vx = 6'($urandom); it.vy = 4'($urandom); it.vz = 6'($urandom);
    it.vtype = 8'($urandom);
    it.ox = 24'($urandom); it.oy = 24'($urandom); it.oz = 24'($urandom);
    it.dx = 16'($urandom); it.dy = 16'($urandom); it.dz = 16'($urandom);
    it.reach = 16'($urandom);
    return it;
  endfunction

  task automatic add_write(int x, int y, int z, int t);
    ray_item_t it;
    it = noise_item();
    it.op = OP_WRITE;
    it.vx = 6'(x); it.vy = 4'(y); it.vz = 6'(z); it.vtype = 8'(t);
    pending_items.push_back(it);
  endtask

  task automatic add_cast(int ox, int oy, int oz, int dx, int dy, int dz, int rc);
    ray_item_t it;
    it = noise_item();
    it.op = OP_CAST;
    it.ox = 24'(ox); it.oy = 24'(oy); it.oz = 24'(oz);
    it.dx = 16'(dx); it.dy = 16'(dy); it.dz = 16'(dz);
    it.reach = 16'(rc);
    pending_items.push_back(it);
  endtask

  // input driver and predictor
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < GX * GY * GZ; i++) grid[i] = '0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_item.op == OP_WRITE)
          grid[(cur_item.vx * GY + cur_item.vy) * GZ + cur_item.vz] = cur_item.vtype;
        else
          awaited_casts.push_back(trace_ray(cur_item));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          opcode <= cur_item.op;
          voxel_x <= cur_item.vx; voxel_y <= cur_item.vy; voxel_z <= cur_item.vz;
          voxel_type <= cur_item.vtype;
          origin_x <= cur_item.ox; origin_y <= cur_item.oy; origin_z <= cur_item.oz;
          dir_x <= cur_item.dx; dir_y <= cur_item.dy; dir_z <= cur_item.dz;
          reach <= cur_item.reach;
          in_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) burst = ~burst;
          in_gap = burst ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cast_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_casts.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = awaited_casts.pop_front();
          if (hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, hit); errors++;
          end
          if (aborted !== e.aborted) begin
            $error("aborted exp %0d got %0d", e.aborted, aborted); errors++;
          end
          if (hit_x !== e.x) begin
            $error("hit_x exp %0d got %0d", e.x, hit_x); errors++;
          end
          if (hit_y !== e.y) begin
            $error("hit_y exp %0d got %0d", e.y, hit_y); errors++;
          end
          if (hit_z !== e.z) begin
            $error("hit_z exp %0d got %0d", e.z, hit_z); errors++;
          end
          if (hit_type !== e.htype) begin
            $error("hit_type exp %0d got %0d", e.htype, hit_type); errors++;
          end
          if (entry_face !== e.face) begin
            $error("entry_face exp %0d got %0d", e.face, entry_face); errors++;
          end
          if (face_known !== e.face_known) begin
            $error("face_known exp %0d got %0d", e.face_known, face_known); errors++;
          end
        end
        out_hold = burst ? 0 : $urandom_range(0, 4);
      end else if (out_valid && out_stall && out_hold > 0) begin
        // count down only while an item is held
        out_hold--;
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int u;
    // directed part
    add_cast(5 << 12, 3 << 12, 5 << 12, 0, 0, 0, 65535);
    add_write(0, 0, 0, 255);
    add_write(63, 15, 63, 1);
    add_write(10, 2, 10, 7);
    add_cast(10 << 12, 2 << 12, 10 << 12, 4096, 0, 0, 512);
    add_cast(2 << 12, (2 << 12) + 2048, 10 << 12, 4096, 0, 0, 65535);
    add_cast(-(3 << 12), (2 << 12) + 100, (10 << 12) + 7, 32767, 0, 0, 65535);
    add_cast(7 << 12, 2 << 12, 7 << 12, 4096, 0, 4096, 65535);
    add_cast(7 << 12, -(1 << 12), 7 << 12, 4096, 4096, 4096, 65535);
    add_cast(5 << 12, 5 << 12, 5 << 12, 0, 32767, 0, 65535);
    add_cast(5 << 12, 5 << 12, 5 << 12, -32768, 0, 0, 65535);
    add_cast(5 << 12, 5 << 12, 5 << 12, 0, 0, -32768, 0);
    add_cast(8388607, 5 << 12, 5 << 12, 100, -7, 3, 65535);
    add_cast(-8388608, -8388608, -8388608, 1, 1, 1, 0);
    add_cast(-8388608, 5 << 12, 5 << 12, 32767, 0, 0, 65535);
    add_cast(62 << 12, 15 << 12, 62 << 12, 4096, 4096, 4096, 65535);
    add_cast((1 << 12) + 50, (1 << 12) + 50, (1 << 12) + 50, -4096, -4096, -4096, 65535);
    add_cast(5 << 12, 5 << 12, 5 << 12, 0, -32768, 0, 2000);
    add_write(10, 2, 10, 0);
    add_cast(9 << 12, 2 << 12, 10 << 12, 4096, 0, 0, 1024);
    // random part: writes mostly packed near the origin, casts mostly started near them in random directions
    for (int i = 0; i < 1250; i++) begin
      u = int'($urandom_range(0, 99));
      if (u < 45) begin
        add_write(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)),
                  int'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 255)));
      end else if (u < 50) begin
        add_write(int'($urandom_range(0, 63)), int'($urandom_range(0, 15)),
                  int'($urandom_range(0, 63)), int'($urandom_range(0, 255)));
      end else if (u < 92) begin
        add_cast(int'($urandom_range(0, 20 << 12)) - (2 << 12),
                 int'($urandom_range(0, 18 << 12)) - (2 << 12),
                 int'($urandom_range(0, 20 << 12)) - (2 << 12),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))),
                 ($urandom_range(0, 31) == 0) ? int'($urandom_range(0, 65535))
                                               : int'($urandom_range(0, 2047)));
      end else begin
        add_cast(int'($signed(24'($urandom))), int'($signed(24'($urandom))),
                 int'($signed(24'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))),
                 int'($urandom_range(0, 1023)));
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_casts.size() != 0)
      @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && awaited_casts.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
